>>> design/assert_macros.svh
// assertion helpers used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define PCVF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked at every rising clock edge outside reset
`define PCVF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/pcvf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcvf_pkg
// Shared widths, codes, command and status types of the collision fix unit.
// ---------------------------------------------------------------------------
package pcvf_pkg;

   localparam int XLEN      = 32;
   localparam int FRAC_BITS = 16;
   localparam int DIMS      = 3;
   localparam int AXES      = 3;
   localparam int CMP_W     = (DIMS > 1) ? $clog2(DIMS) : 1;

   // stream payload widths
   localparam int DATA_W    = 2 * AXES * XLEN;
   localparam int IN_USER_W = 3;

   // configuration port
   localparam int CSR_AW    = 2;
   localparam int CSR_DW    = 31;
   localparam int CDS_W     = 31;
   localparam int RST_W     = 17;
   localparam int TS_W      = 17;
   localparam int MDS_W     = 16;

   // datapath widths
   localparam int DR_W      = XLEN + 1;
   localparam int MAG_W     = XLEN;
   localparam int ACC_W     = 64;
   localparam int R2_W      = CDS_W;
   localparam int NDR_W     = 25;
   localparam int DRM_W     = NDR_W - 1;
   localparam int PROD_W    = DR_W + NDR_W;
   localparam int DOT_W     = 60;
   localparam int QUO_W     = DOT_W - 1;
   localparam int QLO_W     = 30;
   localparam int QHI_W     = QUO_W - QLO_W;
   localparam int K_W       = 18;
   localparam int SK_W      = QUO_W + K_W;
   localparam int G_W       = 35;
   localparam int DELTA_W   = G_W + DRM_W - FRAC_BITS;
   localparam int STEP_W    = DR_W + TS_W - FRAC_BITS;
   localparam int QCNT_W    = $clog2(QUO_W + 1);

   localparam logic [G_W-1:0] G_MAX = {G_W{1'b1}};

   // particle kinds
   localparam logic [1:0] PT_FLUID = 2'd0;
   localparam logic [1:0] PT_GHOST = 2'd2;

   // item kind
   localparam logic OP_CENTRE = 1'b0;

   typedef enum logic [CSR_AW-1:0] {
      CSR_COLL_DIST_SQ,
      CSR_RESTITUTION,
      CSR_TIME_STEP,
      CSR_MIN_DIST_SQ
   } csr_index_type;

   typedef enum logic [4:0] {
      DP_NONE, DP_CENTRE, DP_DR, DP_SQ, DP_SUM, DP_TEST, DP_DMUL, DP_DADD,
      DP_DIV, DP_GLO, DP_GHI, DP_GCAP, DP_UMUL, DP_UADD, DP_FDIF, DP_FMUL,
      DP_FADD, DP_OUT
   } dp_op_type;

   typedef struct packed {
      logic             load;
      dp_op_type        op;
      logic [CMP_W-1:0] comp;
   } dp_cmd_type;

   typedef struct packed {
      logic is_centre;
      logic last;
      logic apply;
      logic dist_ok;
      logic dot_pos;
      logic div_done;
   } dp_status_type;

   // saturate to 32 bits signed, top bit flags saturation
   function automatic logic [XLEN:0] sat32(input logic signed [63:0] v);
      logic [XLEN:0] r;
      if (v > 64'sd2147483647) r = {1'b1, 32'h7fff_ffff};
      else if (v < -64'sd2147483648) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, v[XLEN-1:0]};
      return r;
   endfunction

endpackage

>>> design/pcvf_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcvf_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pcvf_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pcvf_pkg::QUO_W-1:0]  dividend,
   input  logic [pcvf_pkg::R2_W-1:0]   divisor,
   output logic                        done,
   output logic [pcvf_pkg::QUO_W-1:0]  quotient
);
   import pcvf_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [R2_W-1:0]   rem_ff, rem_in;
   logic [R2_W-1:0]   dvs_ff, dvs_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [R2_W:0]     trial;
   logic [R2_W:0]     diff;
   logic              ge;

   // one trial subtract per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[QUO_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = QCNT_W'(QUO_W - 1);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[R2_W-1:0] : trial[R2_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> design/pcvf_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcvf_datapath
// Particle state, config registers and the shared arithmetic of the unit.
// ---------------------------------------------------------------------------
module pcvf_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [pcvf_pkg::CSR_AW-1:0]     csr_addr,
   input  logic [pcvf_pkg::CSR_DW-1:0]     csr_wdata,
   input  logic [pcvf_pkg::IN_USER_W-1:0]  in_user,
   input  logic [pcvf_pkg::DATA_W-1:0]     in_data,
   input  logic                            in_last,
   input  pcvf_pkg::dp_cmd_type            cmd,
   output pcvf_pkg::dp_status_type         status,
   output logic [pcvf_pkg::DATA_W-1:0]     out_data,
   output logic                            out_sat
);
   import pcvf_pkg::*;

   // config registers
   logic [CDS_W-1:0] cds_ff;
   logic [RST_W-1:0] rst_ff;
   logic [TS_W-1:0]  ts_ff;
   logic [MDS_W-1:0] mds_ff;

   // captured item
   logic            it_op_ff;
   logic [1:0]      it_ptype_ff;
   logic            it_last_ff;
   logic [XLEN-1:0] it_pos_ff [AXES];
   logic [XLEN-1:0] it_vel_ff [AXES];

   // centre particle state
   logic [XLEN-1:0] cpos_ff [AXES];
   logic [XLEN-1:0] svel_ff [AXES];
   logic [XLEN-1:0] wvel_ff [AXES];
   logic            fluid_ff;
   logic            sat_ff;

   // working registers
   logic [DR_W-1:0]    dr_ff [AXES];
   logic [DR_W-1:0]    rel_ff [AXES];
   logic [2*MAG_W-1:0] sq_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [R2_W-1:0]    r2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DOT_W-1:0]  dot_ff;
   logic [QLO_W+K_W-1:0] sklo_ff;
   logic [QHI_W+K_W-1:0] skhi_ff;
   logic [G_W-1:0]     g_ff;
   logic [DELTA_W-1:0] delta_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [XLEN-1:0]    npos_ff [AXES];
   logic [DATA_W-1:0]  odata_ff;
   logic               osat_ff;

   // selected component and helpers
   logic [DR_W-1:0]       dr_sel;
   logic [DR_W-1:0]       dr_abs;
   logic [MAG_W-1:0]      m_clamp;
   logic [DR_W-1:0]       rel_sel;
   logic [DR_W-1:0]       rel_abs;
   logic [ACC_W-FRAC_BITS-1:0] r2_full;
   logic [K_W-1:0]        k_val;
   logic [SK_W-1:0]       sk_sum;
   logic [G_W+DRM_W-1:0]  uprod;
   logic [DR_W+TS_W-1:0]  fprod;
   logic signed [63:0]    usum;
   logic signed [63:0]    fsum;
   logic [XLEN:0]         usat;
   logic [XLEN:0]         fsat;
   logic [QUO_W-1:0]      quo;
   logic                  div_done;

   always_comb begin
      dr_sel  = dr_ff[cmd.comp];
      dr_abs  = dr_sel[DR_W-1] ? (~dr_sel + 1'b1) : dr_sel;
      m_clamp = (dr_abs > DR_W'(33'h0_8000_0000)) ? 32'h8000_0000 : dr_abs[MAG_W-1:0];
      rel_sel = rel_ff[cmd.comp];
      rel_abs = rel_sel[DR_W-1] ? (~rel_sel + 1'b1) : rel_sel;
      r2_full = acc_ff[ACC_W-1:FRAC_BITS];
      k_val   = K_W'(1 << FRAC_BITS) + K_W'(rst_ff);
      sk_sum  = {skhi_ff, QLO_W'(0)} + SK_W'(sklo_ff);
      uprod   = g_ff * dr_abs[DRM_W-1:0];
      fprod   = rel_abs * ts_ff;
      // velocity step pushes along minus dr
      if (dr_sel[DR_W-1])
         usum = $signed({{32{wvel_ff[cmd.comp][XLEN-1]}}, wvel_ff[cmd.comp]})
                + $signed({21'b0, delta_ff});
      else
         usum = $signed({{32{wvel_ff[cmd.comp][XLEN-1]}}, wvel_ff[cmd.comp]})
                - $signed({21'b0, delta_ff});
      // position step follows the sign of the velocity change
      if (rel_sel[DR_W-1])
         fsum = $signed({{32{cpos_ff[cmd.comp][XLEN-1]}}, cpos_ff[cmd.comp]})
                - $signed({30'b0, step_ff});
      else
         fsum = $signed({{32{cpos_ff[cmd.comp][XLEN-1]}}, cpos_ff[cmd.comp]})
                + $signed({30'b0, step_ff});
      usat = sat32(usum);
      fsat = sat32(fsum);
   end

   pcvf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == DP_DIV),
      .dividend (dot_ff[QUO_W-1:0]),
      .divisor  (r2_ff),
      .done     (div_done),
      .quotient (quo)
   );

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cds_ff <= CDS_W'(16384);
         rst_ff <= RST_W'(13107);
         ts_ff  <= TS_W'(66);
         mds_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_COLL_DIST_SQ: cds_ff <= csr_wdata[CDS_W-1:0];
            CSR_RESTITUTION:  rst_ff <= csr_wdata[RST_W-1:0];
            CSR_TIME_STEP:    ts_ff  <= csr_wdata[TS_W-1:0];
            CSR_MIN_DIST_SQ:  mds_ff <= csr_wdata[MDS_W-1:0];
         endcase
      end
   end

   // item capture on input transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         it_op_ff    <= in_user[0];
         it_ptype_ff <= in_user[2:1];
         it_last_ff  <= in_last;
         for (int d = 0; d < AXES; d++) begin
            it_pos_ff[d] <= in_data[d*XLEN +: XLEN];
            it_vel_ff[d] <= in_data[(AXES+d)*XLEN +: XLEN];
         end
      end
   end

   // centre state, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < AXES; d++) begin
            cpos_ff[d] <= '0;
            svel_ff[d] <= '0;
            wvel_ff[d] <= '0;
         end
         fluid_ff <= 1'b0;
         sat_ff   <= 1'b0;
      end else begin
         unique case (cmd.op)
            DP_CENTRE: begin
               for (int d = 0; d < AXES; d++) begin
                  cpos_ff[d] <= it_pos_ff[d];
                  svel_ff[d] <= it_vel_ff[d];
                  wvel_ff[d] <= it_vel_ff[d];
               end
               fluid_ff <= (it_ptype_ff == PT_FLUID);
               sat_ff   <= 1'b0;
            end
            DP_GCAP: begin
               if (sk_sum[SK_W-1:G_W+FRAC_BITS+1] != '0) sat_ff <= 1'b1;
            end
            DP_UADD: begin
               wvel_ff[cmd.comp] <= usat[XLEN-1:0];
               if (usat[XLEN]) sat_ff <= 1'b1;
            end
            DP_FADD: begin
               if (fsat[XLEN]) sat_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         DP_DR: begin
            for (int d = 0; d < DIMS; d++)
               dr_ff[d] <= {it_pos_ff[d][XLEN-1], it_pos_ff[d]}
                           - {cpos_ff[d][XLEN-1], cpos_ff[d]};
            acc_ff <= '0;
         end
         DP_SQ:  sq_ff  <= m_clamp * m_clamp;
         DP_SUM: acc_ff <= acc_ff + sq_ff;
         DP_TEST: begin
            r2_ff <= r2_full[R2_W-1:0];
            for (int d = 0; d < DIMS; d++)
               rel_ff[d] <= {wvel_ff[d][XLEN-1], wvel_ff[d]}
                            - {it_vel_ff[d][XLEN-1], it_vel_ff[d]};
            dot_ff <= '0;
         end
         DP_DMUL: prod_ff <= $signed(rel_sel) * $signed(dr_sel[NDR_W-1:0]);
         DP_DADD: dot_ff  <= dot_ff + DOT_W'(prod_ff);
         DP_GLO:  sklo_ff <= quo[QLO_W-1:0] * k_val;
         DP_GHI:  skhi_ff <= quo[QUO_W-1:QLO_W] * k_val;
         DP_GCAP: begin
            if (sk_sum[SK_W-1:G_W+FRAC_BITS+1] != '0) g_ff <= G_MAX;
            else g_ff <= sk_sum[G_W+FRAC_BITS:FRAC_BITS+1];
         end
         DP_UMUL: delta_ff <= uprod[G_W+DRM_W-1:FRAC_BITS];
         DP_FDIF: begin
            for (int d = 0; d < AXES; d++) begin
               rel_ff[d]  <= {wvel_ff[d][XLEN-1], wvel_ff[d]}
                             - {svel_ff[d][XLEN-1], svel_ff[d]};
               npos_ff[d] <= cpos_ff[d];
            end
         end
         DP_FMUL: step_ff <= fprod[DR_W+TS_W-1:FRAC_BITS];
         DP_FADD: npos_ff[cmd.comp] <= fsat[XLEN-1:0];
         DP_OUT: begin
            for (int d = 0; d < AXES; d++) begin
               odata_ff[d*XLEN +: XLEN]        <= npos_ff[d];
               odata_ff[(AXES+d)*XLEN +: XLEN] <= wvel_ff[d];
            end
            osat_ff <= sat_ff;
         end
         default: ;
      endcase
   end

   // status toward the controller
   always_comb begin
      status.is_centre = (it_op_ff == OP_CENTRE);
      status.last      = it_last_ff;
      status.apply     = fluid_ff && (it_ptype_ff != PT_GHOST);
      status.dist_ok   = (r2_full < (ACC_W-FRAC_BITS)'(cds_ff))
                         && (r2_full > (ACC_W-FRAC_BITS)'(mds_ff));
      status.dot_pos   = !dot_ff[DOT_W-1] && (dot_ff != '0);
      status.div_done  = div_done;
   end

   assign out_data = odata_ff;
   assign out_sat  = osat_ff;

endmodule

>>> design/pcvf_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcvf_ctrl
// Sequencer that steps the datapath through one item and owns the handshakes.
// ---------------------------------------------------------------------------
module pcvf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  pcvf_pkg::dp_status_type  status,
   output pcvf_pkg::dp_cmd_type     cmd
);
   import pcvf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECIDE, ST_SQ, ST_SUM, ST_TEST, ST_DMUL, ST_DADD, ST_DCHK,
      ST_DIV, ST_GLO, ST_GHI, ST_GCAP, ST_UMUL, ST_UADD, ST_FDIF, ST_FMUL,
      ST_FADD, ST_OUT
   } state_type;

   state_type        state_ff;
   logic [CMP_W-1:0] comp_ff;
   logic             rvalid_ff;
   state_type        fin_state;
   logic             comp_end;
   logic             out_free;

   always_comb begin
      fin_state = status.last ? ST_FDIF : ST_IDLE;
      comp_end  = (comp_ff == CMP_W'(DIMS - 1));
      out_free  = !rvalid_ff || rsp_tready;
   end

   // command decode
   always_comb begin
      cmd.load = (state_ff == ST_IDLE) && req_tvalid;
      cmd.comp = comp_ff;
      unique case (state_ff)
         ST_DECIDE: cmd.op = status.is_centre ? DP_CENTRE : DP_DR;
         ST_SQ:     cmd.op = DP_SQ;
         ST_SUM:    cmd.op = DP_SUM;
         ST_TEST:   cmd.op = DP_TEST;
         ST_DMUL:   cmd.op = DP_DMUL;
         ST_DADD:   cmd.op = DP_DADD;
         ST_DCHK:   cmd.op = status.dot_pos ? DP_DIV : DP_NONE;
         ST_GLO:    cmd.op = DP_GLO;
         ST_GHI:    cmd.op = DP_GHI;
         ST_GCAP:   cmd.op = DP_GCAP;
         ST_UMUL:   cmd.op = DP_UMUL;
         ST_UADD:   cmd.op = DP_UADD;
         ST_FDIF:   cmd.op = DP_FDIF;
         ST_FMUL:   cmd.op = DP_FMUL;
         ST_FADD:   cmd.op = DP_FADD;
         ST_OUT:    cmd.op = out_free ? DP_OUT : DP_NONE;
         default:   cmd.op = DP_NONE;
      endcase
   end

   // state, component counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         comp_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_OUT) && out_free) rvalid_ff <= 1'b1;
         else if (rsp_tready) rvalid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_tvalid) state_ff <= ST_DECIDE;
            ST_DECIDE: begin
               comp_ff <= '0;
               if (status.is_centre || !status.apply) state_ff <= fin_state;
               else state_ff <= ST_SQ;
            end
            ST_SQ: state_ff <= ST_SUM;
            ST_SUM: begin
               if (comp_end) begin
                  comp_ff  <= '0;
                  state_ff <= ST_TEST;
               end else begin
                  comp_ff  <= comp_ff + 1'b1;
                  state_ff <= ST_SQ;
               end
            end
            ST_TEST: state_ff <= status.dist_ok ? ST_DMUL : fin_state;
            ST_DMUL: state_ff <= ST_DADD;
            ST_DADD: begin
               if (comp_end) begin
                  comp_ff  <= '0;
                  state_ff <= ST_DCHK;
               end else begin
                  comp_ff  <= comp_ff + 1'b1;
                  state_ff <= ST_DMUL;
               end
            end
            ST_DCHK: state_ff <= status.dot_pos ? ST_DIV : fin_state;
            ST_DIV:  if (status.div_done) state_ff <= ST_GLO;
            ST_GLO:  state_ff <= ST_GHI;
            ST_GHI:  state_ff <= ST_GCAP;
            ST_GCAP: state_ff <= ST_UMUL;
            ST_UMUL: state_ff <= ST_UADD;
            ST_UADD: begin
               if (comp_end) begin
                  comp_ff  <= '0;
                  state_ff <= fin_state;
               end else begin
                  comp_ff  <= comp_ff + 1'b1;
                  state_ff <= ST_UMUL;
               end
            end
            ST_FDIF: begin
               comp_ff  <= '0;
               state_ff <= ST_FMUL;
            end
            ST_FMUL: state_ff <= ST_FADD;
            ST_FADD: begin
               if (comp_end) begin
                  comp_ff  <= '0;
                  state_ff <= ST_OUT;
               end else begin
                  comp_ff  <= comp_ff + 1'b1;
                  state_ff <= ST_FMUL;
               end
            end
            ST_OUT: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rvalid_ff;

endmodule

>>> design/particle_collision_velocity_fix_unit.sv
// Throughput: one item in work at a time; the next transfer waits until the sequencer
// is back in ST_IDLE, soonest after a centre or skipped neighbour, then after one out of
// range, then one that separates, last one that collides (its divide runs one bit per cycle).
// Output: with last set the item's work goes on through ST_FDIF, ST_FMUL/ST_FADD per axis
// and ST_OUT, where the input stays closed while the output register still holds an untaken result.
// Reset (synchronous, active high) clears state and loads register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// particle_collision_velocity_fix_unit
// Collision velocity and position correction, one centre particle at a time.
// ---------------------------------------------------------------------------
module particle_collision_velocity_fix_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [pcvf_pkg::CSR_AW-1:0]     csr_addr,
   input  logic [pcvf_pkg::CSR_DW-1:0]     csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
   input  logic [pcvf_pkg::DATA_W-1:0]     req_tdata,
   // op, ptype
   input  logic [pcvf_pkg::IN_USER_W-1:0]  req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
   output logic [pcvf_pkg::DATA_W-1:0]     rsp_tdata,
   // saturated
   output logic [0:0]                      rsp_tuser
);
   import pcvf_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          osat;

   pcvf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcvf_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .in_user   (req_tuser),
      .in_data   (req_tdata),
      .in_last   (req_tlast),
      .cmd       (cmd),
      .status    (status),
      .out_data  (rsp_tdata),
      .out_sat   (osat)
   );

   assign rsp_tuser = osat;

   // checks
   `PCVF_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready, "second item taken while busy")
   `PCVF_ASSERT_NEXT(a_out_load, clock, reset, cmd.op == DP_OUT, rsp_tvalid, "result loaded but not shown")
   `PCVF_ASSERT_NOW(a_div_pos, clock, reset, cmd.op == DP_DIV, status.dot_pos, "divide started on closing test failure")

endmodule

>>> test/tb_particle_collision_velocity_fix_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_particle_collision_velocity_fix_unit
// Self-checking bench for the collision velocity fix unit: directed items
// from a table, then random centre/neighbour runs under several idle phases
// and register settings, each result checked against an in-bench predictor or a row's typed expectation.
// ---------------------------------------------------------------------------
module tb_particle_collision_velocity_fix_unit;
   import pcvf_pkg::*;

   typedef struct {
      logic             op;
      logic [1:0]       ptype;
      logic [31:0]      pos [3];
      logic [31:0]      vel [3];
      logic             last;
   } particle_item_type;

   typedef struct {
      logic [31:0] npos [3];
      logic [31:0] nvel [3];
      logic        sat;
   } fix_result_type;

   typedef struct {
      particle_item_type it;
      logic              has_exp;
      fix_result_type    exp;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic [IN_USER_W-1:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   particle_collision_velocity_fix_unit i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of registers and particle state
   logic [63:0] cds_q = 64'd16384, rest_q = 64'd13107, dt_q = 64'd66, mds_q = 64'd0;
   longint cpos [3], svel [3], wvel [3];
   bit c_fluid, sat_flag;

   fix_result_type expected_fixes[$];
   int errors = 0;
   int send_idle = 0, recv_stall = 0;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
         sat_flag = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat_flag = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic logic [63:0] absval(longint v);
      return v < 0 ? -v : v;
   endfunction

   // one neighbour collision update
   function automatic void collide(longint p [3], longint v [3]);
      longint dr [3];
      logic [63:0] r2sum, r2, s, k, g, m;
      longint dot;
      r2sum = 0;
      dot = 0;
      for (int d = 0; d < 3; d++) begin
         dr[d] = p[d] - cpos[d];
         m = absval(dr[d]);
         if (m > 64'h8000_0000) m = 64'h8000_0000;
         r2sum += m * m;
      end
      r2 = r2sum >> FRAC_BITS;
      if (r2 >= cds_q || r2 <= mds_q) return;
      for (int d = 0; d < 3; d++) dot += (wvel[d] - v[d]) * dr[d];
      if (dot <= 0) return;
      s = 64'(dot) / r2;
      k = (64'd1 << FRAC_BITS) + rest_q;
      if (s > 64'hffff_ffff_ffff_ffff / k) begin
         g = 64'(G_MAX);
         sat_flag = 1;
      end else begin
         g = (s * k) >> (FRAC_BITS + 1);
         if (g > 64'(G_MAX)) begin
            g = 64'(G_MAX);
            sat_flag = 1;
         end
      end
      for (int d = 0; d < 3; d++) begin
         longint delta;
         delta = longint'((g * absval(dr[d])) >> FRAC_BITS);
         wvel[d] = clamp32(dr[d] < 0 ? wvel[d] + delta : wvel[d] - delta);
      end
   endfunction

   // advance predictor, returns 1 with result when last is set
   function automatic bit predict_fix(particle_item_type it, output fix_result_type r);
      longint p [3], v [3];
      for (int d = 0; d < 3; d++) begin
         p[d] = longint'(signed'(it.pos[d]));
         v[d] = longint'(signed'(it.vel[d]));
      end
      if (it.op == OP_CENTRE) begin
         for (int d = 0; d < 3; d++) begin
            cpos[d] = p[d];
            svel[d] = v[d];
            wvel[d] = v[d];
         end
         c_fluid = (it.ptype == PT_FLUID);
         sat_flag = 0;
      end else if (c_fluid && it.ptype != PT_GHOST) begin
         collide(p, v);
      end
      if (!it.last) return 0;
      for (int d = 0; d < 3; d++) begin
         longint dv, stp;
         dv = wvel[d] - svel[d];
         stp = longint'((absval(dv) * dt_q) >> FRAC_BITS);
         r.npos[d] = 32'(clamp32(dv < 0 ? cpos[d] - stp : cpos[d] + stp));
         r.nvel[d] = 32'(wvel[d]);
      end
      r.sat = sat_flag;
      return 1;
   endfunction

   // idle draws
   always @(posedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         fix_result_type e, a;
         for (int d = 0; d < 3; d++) begin
            a.npos[d] = rsp_tdata[32*d +: 32];
            a.nvel[d] = rsp_tdata[96 + 32*d +: 32];
         end
         a.sat = rsp_tuser[0];
         if (expected_fixes.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_tdata);
            errors++;
         end else begin
            e = expected_fixes.pop_front();
            for (int d = 0; d < 3; d++) begin
               if (e.npos[d] !== a.npos[d]) begin
                  $display("%0t: new_pos[%0d] exp %h got %h", $time, d, e.npos[d], a.npos[d]);
                  errors++;
               end
               if (e.nvel[d] !== a.nvel[d]) begin
                  $display("%0t: new_vel[%0d] exp %h got %h", $time, d, e.nvel[d], a.nvel[d]);
                  errors++;
               end
            end
            if (e.sat !== a.sat) begin
               $display("%0t: saturated exp %b got %b", $time, e.sat, a.sat);
               errors++;
            end
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= CSR_DW'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_COLL_DIST_SQ: cds_q = val & 64'h7fff_ffff;
         CSR_RESTITUTION:  rest_q = val & 64'h1ffff;
         CSR_TIME_STEP:    dt_q = val & 64'h1ffff;
         default:          mds_q = val & 64'hffff;
      endcase
   endtask

   // send one item; the row's typed expectation overrides the predictor's
   task automatic send_item(particle_item_type it, bit has_exp, fix_result_type given);
      fix_result_type r;
      while ($urandom_range(99) < send_idle) begin
         @(posedge clock);
         req_tvalid <= 1'b0;
      end
      @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= {it.ptype, it.op};
      req_tlast <= it.last;
      req_tdata <= {it.vel[2], it.vel[1], it.vel[0], it.pos[2], it.pos[1], it.pos[0]};
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
      if (predict_fix(it, r)) expected_fixes.push_back(has_exp ? given : r);
   endtask

   task automatic drain();
      while (expected_fixes.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_val(int sc);
      case ($urandom_range(4))
         0: return $urandom;
         1: return 32'h8000_0000 ^ ($urandom_range(1) ? 32'hffff_ffff : 0);
         default: return 32'($signed(32'($urandom_range(2 * sc))) - sc);
      endcase
   endfunction

   // random centre run with neighbours near the centre
   task automatic random_run(int n);
      particle_item_type it;
      fix_result_type dummy;
      longint c [3];
      it.op = OP_CENTRE;
      it.ptype = ($urandom_range(9) < 7) ? PT_FLUID : 2'($urandom_range(3));
      for (int d = 0; d < 3; d++) begin
         it.pos[d] = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(20000)) - 10000;
         it.vel[d] = rand_val(200000);
         c[d] = longint'(signed'(it.pos[d]));
      end
      it.last = (n == 0);
      send_item(it, 0, dummy);
      for (int i = 0; i < n; i++) begin
         it.op = 1'b1;
         it.ptype = 2'($urandom_range(9) < 6 ? 0 : $urandom_range(3));
         for (int d = 0; d < 3; d++) begin
            it.pos[d] = ($urandom_range(14) == 0) ? $urandom :
                        32'(c[d] + $urandom_range(200) - 100);
            it.vel[d] = rand_val(200000);
         end
         it.last = (i == n - 1);
         send_item(it, 0, dummy);
      end
   endtask

   table_row_type dir_rows[$];

   function automatic table_row_type mk(logic op, logic [1:0] pt, logic [31:0] p,
                                        logic [31:0] v, logic last, bit echo);
      table_row_type row;
      row.it.op = op;
      row.it.ptype = pt;
      row.it.last = last;
      for (int d = 0; d < 3; d++) begin
         row.it.pos[d] = p + 32'(d);
         row.it.vel[d] = v - 32'(d);
         row.exp.npos[d] = p + 32'(d);
         row.exp.nvel[d] = v - 32'(d);
      end
      row.exp.sat = 1'b0;
      row.has_exp = echo;
      return row;
   endfunction

   initial begin
      int phase_idle [4] = '{0, 47, 0, 19};
      int phase_stall [4] = '{0, 0, 47, 19};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: neighbour before any centre, closing result over zero state
      dir_rows.push_back(mk(1, PT_FLUID, 32'h0000_1000, 32'h0000_0000, 1, 0));
      // centre with last emits unchanged, extremes
      dir_rows.push_back(mk(0, PT_FLUID, 32'h7fff_fff0, 32'h8000_0003, 1, 1));
      dir_rows.push_back(mk(0, PT_FLUID, 32'h8000_0000, 32'h7fff_ffff, 1, 1));
      // non-fluid centres pass through whatever neighbours say
      dir_rows.push_back(mk(0, 2'd1, 32'h0000_0000, 32'h0001_0000, 0, 0));
      dir_rows.push_back(mk(1, PT_FLUID, 32'h0000_0010, 32'hffff_0000, 1, 0));
      dir_rows.push_back(mk(0, 2'd3, 32'hffff_ffff, 32'h1234_5678, 0, 0));
      dir_rows.push_back(mk(1, 2'd3, 32'hffff_ffe0, 32'h0000_0000, 1, 0));
      dir_rows.push_back(mk(0, PT_GHOST, 32'h0000_0100, 32'h0, 1, 1));
      // fluid centre: closing, ghost, wall-coded 3, separating, coincident, huge offset
      dir_rows.push_back(mk(0, PT_FLUID, 32'h0000_0000, 32'h0002_0000, 0, 0));
      dir_rows.push_back(mk(1, PT_GHOST, 32'h0000_0020, 32'hfffe_0000, 0, 0));
      dir_rows.push_back(mk(1, PT_FLUID, 32'h0000_0020, 32'hfffe_0000, 0, 0));
      dir_rows.push_back(mk(1, 2'd3, 32'h0000_0010, 32'hffff_0000, 0, 0));
      dir_rows.push_back(mk(1, 2'd1, 32'h0000_0040, 32'h7fff_ffff, 0, 0));
      dir_rows.push_back(mk(1, PT_FLUID, 32'h0000_0000, 32'h8000_0000, 0, 0));
      dir_rows.push_back(mk(1, PT_FLUID, 32'h8000_0000, 32'h7fff_ffff, 1, 0));
      // saturation: big velocity gap, tiny distance
      dir_rows.push_back(mk(0, PT_FLUID, 32'h0000_0000, 32'h7fff_ffff, 0, 0));
      dir_rows.push_back(mk(1, PT_FLUID, 32'h0000_0100, 32'h8000_0000, 1, 0));
      foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].has_exp, dir_rows[i].exp);
      drain();

      // random runs, cycling idle phases and register settings
      for (int ph = 0; ph < 8; ph++) begin
         send_idle = phase_idle[ph % 4];
         recv_stall = phase_stall[ph % 4];
         case (ph)
            1: begin
               write_reg(CSR_COLL_DIST_SQ, 64'h7fff_ffff);
               write_reg(CSR_RESTITUTION, 64'd65536);
               write_reg(CSR_TIME_STEP, 64'd65536);
               write_reg(CSR_MIN_DIST_SQ, 64'd0);
            end
            2: begin
               write_reg(CSR_COLL_DIST_SQ, 64'd0);
               write_reg(CSR_RESTITUTION, 64'd0);
               write_reg(CSR_TIME_STEP, 64'd0);
            end
            3: begin
               write_reg(CSR_COLL_DIST_SQ, 64'd40000);
               write_reg(CSR_MIN_DIST_SQ, 64'd65535);
            end
            4: write_reg(CSR_MIN_DIST_SQ, 64'd5);
            default: begin
               write_reg(CSR_COLL_DIST_SQ, 64'($urandom_range(200000)));
               write_reg(CSR_RESTITUTION, 64'($urandom_range(65536)));
               write_reg(CSR_TIME_STEP, 64'($urandom_range(65536)));
               write_reg(CSR_MIN_DIST_SQ, 64'($urandom_range(30)));
            end
         endcase
         for (int r = 0; r < 12; r++) random_run($urandom_range(6));
         drain();
      end

      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
